@@ rtl/lps_pkg.sv @@
// Shared widths and parameter defaults for the Legendre sequence generator.
package lps_pkg;

	localparam int ARG_W   = 18;
	localparam int VALUE_W = 32;
	localparam int CNT_W   = 6;
	localparam int DEG_W   = 5;

	localparam int MAX_TERMS_DEF       = 32;
	localparam int VALUE_FRAC_BITS_DEF = 24;
	localparam int ARG_FRAC_BITS_DEF   = 16;

endpackage

@@ rtl/lps_mul.sv @@
// Shared signed multiplier with registered product.
module lps_mul #(
	parameter int A_W = lps_pkg::VALUE_W,
	parameter int B_W = lps_pkg::ARG_W
) (
	input  logic                       clk,
	input  logic signed [A_W-1:0]      a,
	input  logic signed [B_W-1:0]      b,
	output logic signed [A_W+B_W-1:0]  p_q
);
	import lps_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

@@ rtl/lps_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
module lps_div #(
	parameter int DVD_W = 43,
	parameter int DVS_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	import lps_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

@@ rtl/legendre_poly_sequence.sv @@
// Legendre P_0..P_{count-1} generator: sequencer around a shared multiplier and divider.
// P_0 is loaded when a word is accepted and P_1 replaces it at the edge it leaves.
// Each higher term takes three passes through the shared multiplier, a subtract step,
// then one restoring-divider step per dividend bit; in_stall is high for the whole run.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops out_valid.
module legendre_poly_sequence #(
	parameter int MAX_TERMS       = lps_pkg::MAX_TERMS_DEF,
	parameter int VALUE_FRAC_BITS = lps_pkg::VALUE_FRAC_BITS_DEF,
	parameter int ARG_FRAC_BITS   = lps_pkg::ARG_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [lps_pkg::ARG_W-1:0]   arg_x,
	input  logic        [lps_pkg::CNT_W-1:0]   term_count,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [lps_pkg::VALUE_W-1:0] poly_value,
	output logic        [lps_pkg::DEG_W-1:0]   degree,
	output logic                               saturated,
	output logic                               last
);
	import lps_pkg::*;

	localparam int T_W     = ARG_W + VALUE_W - ARG_FRAC_BITS;
	localparam int MUL_A_W = (T_W > VALUE_W) ? T_W : VALUE_W;
	localparam int PROD_W  = MUL_A_W + ARG_W;
	localparam int LEFT_W  = T_W + 8;
	localparam int NW      = $clog2(MAX_TERMS + 1);
	localparam int DIFF_W  = ((LEFT_W > VALUE_W + NW) ? LEFT_W : VALUE_W + NW) + 1;
	localparam int UP      = (VALUE_FRAC_BITS >= ARG_FRAC_BITS) ?
		VALUE_FRAC_BITS - ARG_FRAC_BITS : 0;
	localparam int DN      = (VALUE_FRAC_BITS >= ARG_FRAC_BITS) ?
		0 : ARG_FRAC_BITS - VALUE_FRAC_BITS;
	localparam int P1_W    = ARG_W + UP;
	localparam int RES_A   = (DIFF_W + 1 > P1_W) ? DIFF_W + 1 : P1_W;
	localparam int RES_W   = (RES_A > VALUE_W + 1) ? RES_A : VALUE_W + 1;

	localparam logic [VALUE_W-1:0] ONE_VAL = VALUE_W'(64'd1 << VALUE_FRAC_BITS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EMIT = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_MUL3 = 3'd4;
	localparam logic [2:0] ST_SUB  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;

	logic [2:0]                state_q;
	logic signed [ARG_W-1:0]   x_q;
	logic [NW-1:0]             count_q;
	logic [NW-1:0]             n_q;
	logic signed [VALUE_W-1:0] prev_q;
	logic signed [VALUE_W-1:0] pprev_q;
	logic signed [VALUE_W-1:0] val_q;
	logic                      sat_q;
	logic signed [LEFT_W-1:0]  left_q;
	logic                      neg_q;

	logic                      ovalid_q;
	logic signed [VALUE_W-1:0] opoly_q;
	logic [DEG_W-1:0]          odeg_q;
	logic                      osat_q;
	logic                      olast_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [ARG_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	logic                      div_start;
	logic [DIFF_W-1:0]         div_mag;
	logic                      div_done;
	logic [DIFF_W-1:0]         div_quo;

	logic [NW-1:0]             cnt_clamp;
	logic                      in_acc;
	logic                      out_free;
	logic                      is_last;
	logic signed [T_W-1:0]     t_val;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [P1_W-1:0]    p1_w;
	logic signed [RES_W-1:0]   sat_in;
	logic signed [VALUE_W-1:0] sat_val;
	logic                      sat_ovf;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign out_free  = !ovalid_q || !out_stall;
	assign is_last   = NW'(n_q + 1'b1) == count_q;
	assign cnt_clamp = (32'(term_count) > MAX_TERMS) ? NW'(MAX_TERMS) : NW'(term_count);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = MUL_A_W'(prev_q);
		mul_b = x_q;
		case (state_q)
			ST_MUL2: begin
				mul_a = MUL_A_W'(t_val);
				mul_b = ARG_W'({n_q, 1'b0} - 1'b1);
			end
			ST_MUL3: begin
				mul_a = MUL_A_W'(pprev_q);
				mul_b = ARG_W'(n_q - 1'b1);
			end
			default: ;
		endcase
	end

	lps_mul #(
		.A_W (MUL_A_W),
		.B_W (ARG_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// floor shift of x*P_{n-1} back to the value scale
	assign t_val = T_W'(mul_p >>> ARG_FRAC_BITS);
	assign diff  = DIFF_W'(PROD_W'(left_q) - mul_p);

	assign div_start = state_q == ST_SUB;
	assign div_mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	lps_div #(
		.DVD_W (DIFF_W),
		.DVS_W (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign p1_w = (P1_W'(x_q) <<< UP) >>> DN;

	// saturate either the rescaled argument or the signed quotient
	always_comb begin
		if (state_q == ST_EMIT)
			sat_in = RES_W'(p1_w);
		else if (neg_q)
			sat_in = -$signed(RES_W'(div_quo));
		else
			sat_in = $signed(RES_W'(div_quo));
		sat_ovf = !((&sat_in[RES_W-1:VALUE_W-1]) || !(|sat_in[RES_W-1:VALUE_W-1]));
		if (sat_ovf)
			sat_val = sat_in[RES_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
				: {1'b0, {(VALUE_W-1){1'b1}}};
		else
			sat_val = VALUE_W'(sat_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			count_q  <= '0;
			n_q      <= '0;
			sat_q    <= 1'b0;
		end else begin
			// in the emit step the valid flag is handled below
			if (ovalid_q && !out_stall && state_q != ST_EMIT)
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						count_q <= cnt_clamp;
						n_q     <= '0;
						sat_q   <= 1'b0;
						if (cnt_clamp != '0)
							state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							n_q <= n_q + 1'b1;
							if (n_q == '0)
								sat_q <= sat_q | sat_ovf;
							else
								state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_SUB;
				ST_SUB:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						sat_q   <= sat_q | sat_ovf;
						state_q <= ST_EMIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			x_q   <= arg_x;
			val_q <= ONE_VAL;
		end
		if (state_q == ST_EMIT && out_free) begin
			opoly_q <= val_q;
			odeg_q  <= DEG_W'(n_q);
			osat_q  <= sat_q;
			olast_q <= is_last;
			pprev_q <= prev_q;
			prev_q  <= val_q;
			if (n_q == '0)
				val_q <= sat_val;
		end
		if (state_q == ST_MUL3)
			left_q <= LEFT_W'(mul_p);
		if (state_q == ST_SUB)
			neg_q <= diff[DIFF_W-1];
		if (state_q == ST_DIV && div_done)
			val_q <= sat_val;
	end

	assign out_valid  = ovalid_q;
	assign poly_value = opoly_q;
	assign degree     = odeg_q;
	assign saturated  = osat_q;
	assign last       = olast_q;

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !olast_q) |-> state_q != ST_IDLE)
		else $error("non-final word pending with sequencer idle");

	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_stall && osat_q && !olast_q) |=> (!ovalid_q || osat_q))
		else $error("saturation flag dropped within a run");

endmodule
